// File: sv/egbp_pkg.sv
`timescale 1ns / 1ps

package egbp_pkg;

    // Widest raw field that a command may write.
    localparam int FIELD_BITS_DEF = 32;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 2;

    // Largest unsigned Exp-Golomb value whose codeword fits in 31 bits.
    localparam logic [31:0] EG_MAX_VALUE = 32'd65534;

    localparam logic [2:0] MODE_RAW     = 3'd0;
    localparam logic [2:0] MODE_UE      = 3'd1;
    localparam logic [2:0] MODE_SE      = 3'd2;
    localparam logic [2:0] MODE_ALIGN   = 3'd3;
    localparam logic [2:0] MODE_FLUSH   = 3'd4;
    localparam logic [2:0] MODE_RESTART = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIZE,
        ST_WRITE,
        ST_STATUS
    } state_t;

endpackage

// File: sv/exp_golomb_bit_packer_top.sv
`timescale 1ns / 1ps
// Operation: a command is accepted in ST_IDLE; ST_SIZE then sizes an Exp-Golomb
// code (one bit of the code word per cycle); ST_WRITE writes chunks of up to 8 bits
// (at most 5), one chunk per cycle except while a full byte waits on the output, and
// ST_STATUS sends the status beat once the output is free. One command at a time.
// Reset: aresetn is synchronous and active low; it clears the partial byte, the counters
// and the output valid.
module exp_golomb_bit_packer_top #(
    parameter int FIELD_BITS = egbp_pkg::FIELD_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // mode[2:0], raw_value[34:3], signed_value[50:35], length[56:51], zero fill above
    input  logic [egbp_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_byte[7:0], total_bits[39:8], total_bytes[71:40]
    output logic [egbp_pkg::M_TDATA_W-1:0]  m_tdata,
    // byte_valid[0], range_error[1]
    output logic [egbp_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                             m_tlast
);

    logic [2:0]         in_mode;
    logic [31:0]        in_raw;
    logic signed [15:0] in_signed;
    logic [5:0]         in_length;

    assign in_mode   = s_tdata[2:0];
    assign in_raw    = s_tdata[34:3];
    assign in_signed = s_tdata[50:35];
    assign in_length = s_tdata[56:51];

    egbp_pkg::state_t state_reg, state_next;

    logic [31:0] val_reg, val_next;
    logic [5:0]  rem_reg, rem_next;
    logic [15:0] tmp_reg, tmp_next;
    logic [3:0]  k_reg, k_next;
    logic        err_reg, err_next;
    logic [7:0]  partial_reg, partial_next;
    logic [3:0]  free_reg, free_next;
    logic [31:0] bits_reg, bits_next;
    logic [31:0] bytes_reg, bytes_next;

    logic        m_valid_reg, m_valid_next;
    logic [7:0]  obyte_reg, obyte_next;
    logic        obv_reg, obv_next;
    logic        olast_reg, olast_next;
    logic        oerr_reg, oerr_next;
    logic [31:0] obits_reg, obits_next;
    logic [31:0] obytes_reg, obytes_next;

    logic        out_free;
    logic        accept;

    logic        commit_en;
    logic [5:0]  commit_n;
    logic [5:0]  byte_sum;

    logic [5:0]  raw_len;
    logic [15:0] ue_code;
    logic [15:0] se_neg;
    logic [15:0] se_code;
    logic        se_bad;

    logic [3:0]  take;
    logic [5:0]  shift_amt;
    logic [31:0] shifted;
    logic [7:0]  chunk_mask;
    logic [7:0]  chunk;
    logic [7:0]  partial_new;
    logic [3:0]  free_new;

    assign s_tready = (state_reg == egbp_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {obytes_reg, obits_reg, obyte_reg};
    assign m_tuser  = {oerr_reg, obv_reg};
    assign m_tlast  = olast_reg;

    assign raw_len = (in_length > 6'(FIELD_BITS)) ? 6'(FIELD_BITS) : in_length;
    assign ue_code = in_raw[15:0] + 16'd1;
    assign se_neg  = 16'(-in_signed);
    assign se_bad  = (in_signed == 16'sh8000);
    assign se_code = (in_signed > 16'sd0) ? {in_signed[14:0], 1'b0} : {se_neg[14:0], 1'b1};

    // Bytes completed by a command follow from the bits already in the partial byte plus its own bits.
    assign byte_sum = {2'b00, 4'(4'd8 - free_reg)} + commit_n;

    // Shared chunk unit: up to one byte of code bits per cycle unless the output stalls.
    assign take        = (rem_reg < {2'b00, free_reg}) ? rem_reg[3:0] : free_reg;
    assign shift_amt   = rem_reg - {2'b00, take};
    assign shifted     = val_reg >> shift_amt;
    assign chunk_mask  = 8'((9'd1 << take) - 9'd1);
    assign chunk       = shifted[7:0] & chunk_mask;
    assign partial_new = partial_reg | (chunk << 3'(free_reg - take));
    assign free_new    = free_reg - take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= egbp_pkg::ST_IDLE;
            partial_reg <= 8'd0;
            free_reg    <= 4'd8;
            bits_reg    <= 32'd0;
            bytes_reg   <= 32'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            partial_reg <= partial_next;
            free_reg    <= free_next;
            bits_reg    <= bits_next;
            bytes_reg   <= bytes_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg    <= val_next;
        rem_reg    <= rem_next;
        tmp_reg    <= tmp_next;
        k_reg      <= k_next;
        err_reg    <= err_next;
        obyte_reg  <= obyte_next;
        obv_reg    <= obv_next;
        olast_reg  <= olast_next;
        oerr_reg   <= oerr_next;
        obits_reg  <= obits_next;
        obytes_reg <= obytes_next;
    end

    always_comb begin
        state_next   = state_reg;
        val_next     = val_reg;
        rem_next     = rem_reg;
        tmp_next     = tmp_reg;
        k_next       = k_reg;
        err_next     = err_reg;
        partial_next = partial_reg;
        free_next    = free_reg;
        bits_next    = bits_reg;
        bytes_next   = bytes_reg;
        commit_en    = 1'b0;
        commit_n     = 6'd0;

        m_valid_next = m_valid_reg && !m_tready;
        obyte_next   = obyte_reg;
        obv_next     = obv_reg;
        olast_next   = olast_reg;
        oerr_next    = oerr_reg;
        obits_next   = obits_reg;
        obytes_next  = obytes_reg;

        case (state_reg)
            egbp_pkg::ST_IDLE: begin
                if (accept) begin
                    err_next = 1'b0;
                    k_next   = 4'd0;
                    case (in_mode)
                        egbp_pkg::MODE_RAW: begin
                            val_next   = in_raw;
                            commit_en  = 1'b1;
                            commit_n   = raw_len;
                            state_next = egbp_pkg::ST_WRITE;
                        end
                        egbp_pkg::MODE_UE: begin
                            if (in_raw > egbp_pkg::EG_MAX_VALUE) begin
                                err_next   = 1'b1;
                                state_next = egbp_pkg::ST_STATUS;
                            end else begin
                                val_next   = {16'd0, ue_code};
                                tmp_next   = ue_code >> 1;
                                state_next = egbp_pkg::ST_SIZE;
                            end
                        end
                        egbp_pkg::MODE_SE: begin
                            if (se_bad) begin
                                err_next   = 1'b1;
                                state_next = egbp_pkg::ST_STATUS;
                            end else begin
                                val_next   = {16'd0, se_code};
                                tmp_next   = se_code >> 1;
                                state_next = egbp_pkg::ST_SIZE;
                            end
                        end
                        egbp_pkg::MODE_ALIGN: begin
                            val_next   = 32'd0;
                            commit_en  = 1'b1;
                            commit_n   = (free_reg == 4'd8) ? 6'd0 : {2'b00, free_reg};
                            state_next = egbp_pkg::ST_WRITE;
                        end
                        egbp_pkg::MODE_FLUSH: begin
                            // A stop bit followed by zeros fills exactly the free bits.
                            val_next   = 32'd1 << (free_reg - 4'd1);
                            commit_en  = 1'b1;
                            commit_n   = {2'b00, free_reg};
                            state_next = egbp_pkg::ST_WRITE;
                        end
                        egbp_pkg::MODE_RESTART: begin
                            partial_next = 8'd0;
                            free_next    = 4'd8;
                            bits_next    = 32'd0;
                            bytes_next   = 32'd0;
                            state_next   = egbp_pkg::ST_STATUS;
                        end
                        default: begin
                            state_next = egbp_pkg::ST_STATUS;
                        end
                    endcase
                end
            end
            egbp_pkg::ST_SIZE: begin
                // Find the position of the leading one, one bit per cycle.
                if (tmp_reg != 16'd0) begin
                    tmp_next = tmp_reg >> 1;
                    k_next   = k_reg + 4'd1;
                end else begin
                    commit_en  = 1'b1;
                    commit_n   = {1'b0, k_reg, 1'b1};
                    state_next = egbp_pkg::ST_WRITE;
                end
            end
            egbp_pkg::ST_WRITE: begin
                if (rem_reg == 6'd0) begin
                    state_next = egbp_pkg::ST_STATUS;
                end else if (free_new != 4'd0) begin
                    partial_next = partial_new;
                    free_next    = free_new;
                    rem_next     = rem_reg - {2'b00, take};
                end else if (out_free) begin
                    partial_next = 8'd0;
                    free_next    = 4'd8;
                    rem_next     = rem_reg - {2'b00, take};
                    m_valid_next = 1'b1;
                    obyte_next   = partial_new;
                    obv_next     = 1'b1;
                    olast_next   = 1'b0;
                    oerr_next    = 1'b0;
                    obits_next   = bits_reg;
                    obytes_next  = bytes_reg;
                end
            end
            egbp_pkg::ST_STATUS: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    obyte_next   = 8'd0;
                    obv_next     = 1'b0;
                    olast_next   = 1'b1;
                    oerr_next    = err_reg;
                    obits_next   = bits_reg;
                    obytes_next  = bytes_reg;
                    state_next   = egbp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = egbp_pkg::ST_IDLE;
            end
        endcase

        // The counters move to their after-command values before the first beat goes out.
        if (commit_en) begin
            rem_next   = commit_n;
            bits_next  = bits_reg + {26'd0, commit_n};
            bytes_next = bytes_reg + {29'd0, byte_sum[5:3]};
        end
    end

endmodule

// File: sv/egbp_checker.sv
`timescale 1ns / 1ps

module egbp_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [egbp_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [egbp_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                            m_tlast
);

    // The packer works on one command at a time.
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken in the cycle after a command beat");

    // A status beat carries no byte.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !m_tuser[0] && m_tdata[7:0] == 8'd0)
        else $error("status beat carries a byte");

    // A byte beat is never the last one and never flags an error.
    a_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[0] && !m_tuser[1])
        else $error("byte beat with bad flags");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled output beat changed");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind exp_golomb_bit_packer_top egbp_checker u_egbp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: tb/exp_golomb_bit_packer_top_tb.sv
`timescale 1ns / 1ps

module exp_golomb_bit_packer_top_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 40;
    localparam int RANDOM_PER_PHASE = 45;

    typedef struct {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        last;
        logic        range_error;
        logic [31:0] total_bits;
        logic [31:0] total_bytes;
    } packer_beat_t;

    class packer_scoreboard;
        logic [7:0]   partial;
        int unsigned  free_bits;
        logic [31:0]  bit_count;
        logic [31:0]  byte_count;
        logic [7:0]   finished_bytes[$];
        packer_beat_t pending_stream_beats[$];
        int           errors;

        function new();
            errors = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            partial    = 8'h00;
            free_bits  = 8;
            bit_count  = 32'd0;
            byte_count = 32'd0;
        endfunction

        function void put_bit(logic b);
            partial[free_bits - 1] = b;
            free_bits--;
            bit_count++;
            if (free_bits == 0) begin
                finished_bytes.push_back(partial);
                byte_count++;
                partial   = 8'h00;
                free_bits = 8;
            end
        endfunction

        // Bits go out MSB first, starting at bit n-1 of the value.
        function void put_bits(logic [31:0] value, int unsigned n);
            for (int i = int'(n) - 1; i >= 0; i--) begin
                put_bit(value[i]);
            end
        endfunction

        // Returns 0 when the codeword would exceed 31 bits and nothing is written.
        function bit put_exp_golomb(logic [31:0] value);
            logic [31:0] code;
            int unsigned prefix;
            if (value > egbp_pkg::EG_MAX_VALUE) begin
                return 1'b0;
            end
            code   = value + 32'd1;
            prefix = 0;
            while ((code >> (prefix + 1)) != 0) begin
                prefix++;
            end
            put_bits(code, 2 * prefix + 1);
            return 1'b1;
        endfunction

        function void pad_to_byte();
            if (free_bits != 8) begin
                put_bits(32'd0, free_bits);
            end
        endfunction

        function void note_command(logic [2:0] mode, logic [31:0] raw, logic [15:0] sval,
                                   logic [5:0] len);
            int unsigned  nbits;
            int           s;
            logic [31:0]  mapped;
            logic         range_err;
            packer_beat_t b;
            range_err = 1'b0;
            finished_bytes.delete();
            case (mode)
                egbp_pkg::MODE_RAW: begin
                    nbits = (len > egbp_pkg::FIELD_BITS_DEF) ? egbp_pkg::FIELD_BITS_DEF : len;
                    if (nbits > 0) begin
                        put_bits(raw & ((nbits >= 32) ? 32'hffff_ffff : ((32'd1 << nbits) - 1)),
                                 nbits);
                    end
                end
                egbp_pkg::MODE_UE: begin
                    range_err = !put_exp_golomb(raw);
                end
                egbp_pkg::MODE_SE: begin
                    s = $signed(sval);
                    mapped = (s <= 0) ? 32'(-2 * s) : 32'(2 * s - 1);
                    range_err = !put_exp_golomb(mapped);
                end
                egbp_pkg::MODE_ALIGN: begin
                    pad_to_byte();
                end
                egbp_pkg::MODE_FLUSH: begin
                    put_bit(1'b1);
                    pad_to_byte();
                end
                egbp_pkg::MODE_RESTART: begin
                    clear_stream();
                    finished_bytes.delete();
                end
                default: begin
                end
            endcase
            // Every beat of a command carries the counters as they stand after it.
            foreach (finished_bytes[i]) begin
                b = '{finished_bytes[i], 1'b1, 1'b0, 1'b0, bit_count, byte_count};
                pending_stream_beats.push_back(b);
            end
            b = '{8'h00, 1'b0, 1'b1, range_err, bit_count, byte_count};
            pending_stream_beats.push_back(b);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch in %s at %0t: got 0x%0h, expected 0x%0h",
                     what, $time, got, want);
        endtask

        task check_beat(logic [egbp_pkg::M_TDATA_W-1:0] tdata,
                        logic [egbp_pkg::M_TUSER_W-1:0] tuser, logic tlast);
            packer_beat_t want;
            if (pending_stream_beats.size() == 0) begin
                report_mismatch("beat with no command pending (tlast)", 32'(tlast), 32'd0);
                return;
            end
            want = pending_stream_beats.pop_front();
            if (tdata[7:0] !== want.out_byte) begin
                report_mismatch("out_byte", 32'(tdata[7:0]), 32'(want.out_byte));
            end
            if (tdata[39:8] !== want.total_bits) begin
                report_mismatch("total_bits", tdata[39:8], want.total_bits);
            end
            if (tdata[71:40] !== want.total_bytes) begin
                report_mismatch("total_bytes", tdata[71:40], want.total_bytes);
            end
            if (tuser[0] !== want.byte_valid) begin
                report_mismatch("byte_valid", 32'(tuser[0]), 32'(want.byte_valid));
            end
            if (tuser[1] !== want.range_error) begin
                report_mismatch("range_error", 32'(tuser[1]), 32'(want.range_error));
            end
            if (tlast !== want.last) begin
                report_mismatch("tlast", 32'(tlast), 32'(want.last));
            end
        endtask
    endclass

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [egbp_pkg::S_TDATA_W-1:0]  s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [egbp_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [egbp_pkg::M_TUSER_W-1:0]  m_tuser;
    logic                            m_tlast;

    packer_scoreboard sb;
    int src_idle_pct;
    int snk_idle_pct;
    int hold_cycles;
    int cycle_count;

    exp_golomb_bit_packer_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus a long hold-off when one is requested.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else begin
                m_tready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_beat(m_tdata, m_tuser, m_tlast);
        end
    end

    task automatic send_cmd(logic [2:0] mode, logic [31:0] raw, logic [15:0] sval,
                            logic [5:0] len);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, len, sval, raw, mode};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        sb.note_command(mode, raw, sval, len);
    endtask

    // Mostly well-formed commands; fields a mode does not use are left random.
    task automatic send_random_cmd();
        int unsigned pick;
        logic [2:0]  mode;
        logic [31:0] raw;
        logic [15:0] sval;
        logic [5:0]  len;
        pick = $urandom_range(99);
        raw  = $urandom;
        sval = 16'($urandom);
        len  = 6'($urandom);
        if (pick < 35) begin
            mode = egbp_pkg::MODE_RAW;
            if ($urandom_range(9) != 0) begin
                len = 6'($urandom_range(32));
            end
        end else if (pick < 55) begin
            mode = egbp_pkg::MODE_UE;
            case ($urandom_range(9))
                0:       raw = raw;
                1, 2:    raw = $urandom_range(egbp_pkg::EG_MAX_VALUE);
                3:       raw = egbp_pkg::EG_MAX_VALUE + $urandom_range(3) - 32'd1;
                default: raw = $urandom_range(300);
            endcase
        end else if (pick < 75) begin
            mode = egbp_pkg::MODE_SE;
            if ($urandom_range(2) != 0) begin
                sval = 16'($signed($urandom_range(400)) - 200);
            end
        end else if (pick < 84) begin
            mode = egbp_pkg::MODE_ALIGN;
        end else if (pick < 92) begin
            mode = egbp_pkg::MODE_FLUSH;
        end else if (pick < 96) begin
            mode = egbp_pkg::MODE_RESTART;
        end else begin
            mode = 3'($urandom_range(7, 6));
        end
        send_cmd(mode, raw, sval, len);
    endtask

    initial begin
        sb           = new();
        cycle_count  = 0;
        hold_cycles  = 0;
        src_idle_pct = 19;
        snk_idle_pct = 56;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed commands: field extremes and each corner of the stream.
        send_cmd(egbp_pkg::MODE_RAW, 32'h0000_0001, 16'h0000, 6'd0);
        send_cmd(egbp_pkg::MODE_RAW, 32'h0000_0001, 16'h0000, 6'd1);
        send_cmd(egbp_pkg::MODE_RAW, 32'hffff_ffff, 16'hffff, 6'd32);
        send_cmd(egbp_pkg::MODE_RAW, 32'ha5a5_5a5a, 16'h0000, 6'd63);
        send_cmd(egbp_pkg::MODE_RAW, 32'hffff_ffd5, 16'h0000, 6'd5);
        send_cmd(egbp_pkg::MODE_ALIGN, 32'hffff_ffff, 16'hffff, 6'd63);
        send_cmd(egbp_pkg::MODE_ALIGN, 32'h0, 16'h0, 6'd0);
        send_cmd(egbp_pkg::MODE_UE, 32'd0, 16'h0, 6'd0);
        send_cmd(egbp_pkg::MODE_UE, egbp_pkg::EG_MAX_VALUE, 16'h0, 6'd0);
        send_cmd(egbp_pkg::MODE_UE, egbp_pkg::EG_MAX_VALUE + 32'd1, 16'h0, 6'd0);
        send_cmd(egbp_pkg::MODE_UE, 32'hffff_ffff, 16'h0, 6'd0);
        send_cmd(egbp_pkg::MODE_SE, 32'h0, 16'sd0, 6'd0);
        send_cmd(egbp_pkg::MODE_SE, 32'h0, 16'sd1, 6'd0);
        send_cmd(egbp_pkg::MODE_SE, 32'h0, -16'sd1, 6'd0);
        send_cmd(egbp_pkg::MODE_SE, 32'h0, 16'sd32767, 6'd0);
        send_cmd(egbp_pkg::MODE_SE, 32'h0, -16'sd32767, 6'd0);
        send_cmd(egbp_pkg::MODE_SE, 32'h0, 16'h8000, 6'd0);
        send_cmd(egbp_pkg::MODE_RAW, 32'h5, 16'h0, 6'd3);
        send_cmd(egbp_pkg::MODE_FLUSH, 32'h0, 16'h0, 6'd0);
        send_cmd(egbp_pkg::MODE_FLUSH, 32'h0, 16'h0, 6'd0);
        send_cmd(3'd6, 32'h1234_5678, 16'h1234, 6'd9);
        send_cmd(3'd7, 32'hffff_ffff, 16'hffff, 6'd63);
        send_cmd(egbp_pkg::MODE_RAW, 32'h3, 16'h0, 6'd3);
        send_cmd(egbp_pkg::MODE_RESTART, 32'hffff_ffff, 16'hffff, 6'd63);
        send_cmd(egbp_pkg::MODE_RAW, 32'h7, 16'h0, 6'd7);

        for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            send_random_cmd();
        end

        src_idle_pct = 56;
        snk_idle_pct = 19;
        for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            send_random_cmd();
        end

        // No idling, but first a long output stall so the input side backs up.
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_cycles  = 400;
        for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            send_random_cmd();
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending_stream_beats.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
